/* rtl/mklsc_pkg.sv */
// Shared types and constants of the multi-KPI link split controller.
// Used by mklsc_ctrl, mklsc_dp and the top level; no dependencies.
package mklsc_pkg;

  localparam int DVD_W    = 84;
  localparam int DVS_W    = 64;
  localparam int QUO_W    = 32;
  localparam int DIV_ITER = DVD_W;
  localparam int CNT_W    = $clog2(DIV_ITER);

  localparam logic [3:0]  SHARE_MIN    = 4'd2;
  localparam logic [3:0]  SHARE_MAX    = 4'd8;
  localparam logic [3:0]  SHARE_RESET  = 4'd7;
  localparam logic [3:0]  SHARE_TOTAL  = 4'd10;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] VIDEO_PORT_LO = 16'd43000;
  localparam logic [15:0] VIDEO_PORT_HI = 16'd43999;
  localparam logic [9:0]  SCORE_MAX    = 10'd1000;
  localparam logic [19:0] LOSS_FULL    = 20'd1000000;

  localparam logic [2:0] REG_AP6_ADDR  = 3'd0;
  localparam logic [2:0] REG_REF_LOAD  = 3'd1;
  localparam logic [2:0] REG_REF_DELAY = 3'd2;
  localparam logic [2:0] REG_REF_LOSS  = 3'd3;
  localparam logic [2:0] REG_UPPER     = 3'd4;
  localparam logic [2:0] REG_LOWER     = 3'd5;
  localparam logic [2:0] REG_DWELL     = 3'd6;
  localparam logic [2:0] REG_STEP      = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_DELAY = 3'd1,
    OP_LOSS  = 3'd2,
    OP_LSC   = 3'd3,
    OP_DSC   = 3'd4,
    OP_SSC   = 3'd5,
    OP_SCORE = 3'd6
  } op_t;

  typedef struct packed {
    logic acc_en;
    logic prep;
    logic run;
    logic store;
    logic commit;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

/* rtl/multi_kpi_link_split_controller.sv */
// Channel   Handshake          Payload
// in_       in_valid/in_ready  one flow record, in_last_flow closes the window
// out_      out_valid/out_ready ratios, score and window KPIs
// cfg_      cfg_we             cfg_index selects register, cfg_wdata value
// A record without in_last_flow only updates the window. A closing record runs
// the accept step, six divisions on the shared one-bit-per-cycle restoring
// divider, the weighted score and a final commit. The commit waits while a
// previous result is not yet taken. Reset (rst_n, synchronous) restores the
// register defaults, clears window sums and sets the 6 GHz share to 7.
// Depends on mklsc_pkg, mklsc_ctrl and mklsc_dp.
module multi_kpi_link_split_controller import mklsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_flow_valid,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_dest_addr,
  input  logic [47:0] in_rx_bytes,
  input  logic [31:0] in_tx_packets,
  input  logic [31:0] in_rx_packets,
  input  logic [47:0] in_delay_sum_us,
  input  logic [31:0] in_now_ms,
  input  logic        in_last_flow,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_ratio_6ghz_tenths,
  output logic [3:0]  out_ratio_5ghz_tenths,
  output logic [9:0]  out_score_permille,
  output logic [31:0] out_load_kbps,
  output logic [31:0] out_mean_delay_us,
  output logic [19:0] out_loss_ppm,
  output logic [15:0] out_heavy_flows,
  output logic        out_ratio_changed
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mklsc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_last_flow (in_last_flow),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  mklsc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_flow_valid         (in_flow_valid),
    .in_protocol           (in_protocol),
    .in_dest_port          (in_dest_port),
    .in_dest_addr          (in_dest_addr),
    .in_rx_bytes           (in_rx_bytes),
    .in_tx_packets         (in_tx_packets),
    .in_rx_packets         (in_rx_packets),
    .in_delay_sum_us       (in_delay_sum_us),
    .in_now_ms             (in_now_ms),
    .out_ratio_6ghz_tenths (out_ratio_6ghz_tenths),
    .out_ratio_5ghz_tenths (out_ratio_5ghz_tenths),
    .out_score_permille    (out_score_permille),
    .out_load_kbps         (out_load_kbps),
    .out_mean_delay_us     (out_mean_delay_us),
    .out_loss_ppm          (out_loss_ppm),
    .out_heavy_flows       (out_heavy_flows),
    .out_ratio_changed     (out_ratio_changed)
  );

endmodule

/* rtl/mklsc_ctrl.sv */
// Sequencer of the link split controller: item intake and evaluation steps.
// Depends on mklsc_pkg; drives mklsc_dp through dp_cmd_t, reads dp_sts_t.
module mklsc_ctrl import mklsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_last_flow,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.op        = op_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last_flow) begin
            op_nxt    = OP_LOAD;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        if (op_r == OP_SCORE) begin
          state_nxt = ST_STORE;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (sts.div_done) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (op_r == OP_SCORE) begin
          state_nxt = ST_FIN;
        end else begin
          op_nxt    = op_t'(op_r + 3'd1);
          state_nxt = ST_PREP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/mklsc_dp.sv */
// Datapath of the link split controller: registers, window sums, shared
// restoring divider, scores and ratio stepping. Depends on mklsc_pkg.
module mklsc_dp import mklsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_flow_valid,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_dest_addr,
  input  logic [47:0] in_rx_bytes,
  input  logic [31:0] in_tx_packets,
  input  logic [31:0] in_rx_packets,
  input  logic [47:0] in_delay_sum_us,
  input  logic [31:0] in_now_ms,
  output logic [3:0]  out_ratio_6ghz_tenths,
  output logic [3:0]  out_ratio_5ghz_tenths,
  output logic [9:0]  out_score_permille,
  output logic [31:0] out_load_kbps,
  output logic [31:0] out_mean_delay_us,
  output logic [19:0] out_loss_ppm,
  output logic [15:0] out_heavy_flows,
  output logic        out_ratio_changed
);

  logic [31:0] ap6_r;
  logic [23:0] ref_load_r, ref_delay_r;
  logic [19:0] ref_loss_r;
  logic [9:0]  upper_r, lower_r;
  logic [15:0] dwell_r;
  logic [2:0]  step_r;

  logic        first_r;
  logic [31:0] prev_time_r, last_change_r, now_r;
  logic [63:0] prev_rx_r, acc_rx_r, acc_tx_r, acc_rxp_r, acc_dly_r;
  logic [15:0] heavy_r;
  logic [3:0]  share_r;

  logic [63:0] diff_r;
  logic [77:0] prod_r;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt, rem_r;
  logic [QUO_W-1:0] quo_r;
  logic             sat_r;
  logic [CNT_W-1:0] cnt_r;

  logic [31:0] load_r, delay_r;
  logic [19:0] loss_r;
  logic [9:0]  lsc_r, dsc_r, ssc_r, score_r;
  logic [19:0] sum_r;

  logic        hit;
  logic [DVS_W:0] rem_sh;
  logic        ge;
  logic [31:0] quo_sat;
  logic [9:0]  quo_clamp;
  logic [31:0] dt;
  logic [63:0] db;
  logic [19:0] score_sum;
  logic [40:0] score_prod;
  logic [4:0]  sh5, st5;
  logic        dwell_ok;
  logic [3:0]  share_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap6_r       <= '0;
      ref_load_r  <= 24'd40000;
      ref_delay_r <= 24'd50000;
      ref_loss_r  <= 20'd50000;
      upper_r     <= 10'd700;
      lower_r     <= 10'd400;
      dwell_r     <= 16'd2000;
      step_r      <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AP6_ADDR:  ap6_r       <= cfg_wdata;
        REG_REF_LOAD:  ref_load_r  <= cfg_wdata[23:0];
        REG_REF_DELAY: ref_delay_r <= cfg_wdata[23:0];
        REG_REF_LOSS:  ref_loss_r  <= cfg_wdata[19:0];
        REG_UPPER:     upper_r     <= cfg_wdata[9:0];
        REG_LOWER:     lower_r     <= cfg_wdata[9:0];
        REG_DWELL:     dwell_r     <= cfg_wdata[15:0];
        REG_STEP:      step_r      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign hit = in_flow_valid && (in_dest_addr == ap6_r) &&
               ((in_protocol == PROTO_TCP) ||
                ((in_protocol == PROTO_UDP) && (in_dest_port >= VIDEO_PORT_LO) &&
                 (in_dest_port <= VIDEO_PORT_HI)));

  // hysteresis with dwell time
  always_comb begin
    sh5       = {1'b0, share_r};
    st5       = {2'b0, step_r};
    dwell_ok  = (now_r >= last_change_r) && ((now_r - last_change_r) >= {16'b0, dwell_r});
    share_new = share_r;
    if (dwell_ok) begin
      if ((score_r > upper_r) && (share_r > SHARE_MIN)) begin
        share_new = (sh5 >= ({1'b0, SHARE_MIN} + st5)) ? 4'(sh5 - st5) : SHARE_MIN;
      end else if ((score_r < lower_r) && (share_r < SHARE_MAX)) begin
        share_new = ((sh5 + st5) <= {1'b0, SHARE_MAX}) ? 4'(sh5 + st5) : SHARE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r       <= 1'b1;
      prev_time_r   <= '0;
      prev_rx_r     <= '0;
      share_r       <= SHARE_RESET;
      last_change_r <= '0;
      acc_rx_r      <= '0;
      acc_tx_r      <= '0;
      acc_rxp_r     <= '0;
      acc_dly_r     <= '0;
      heavy_r       <= '0;
    end else if (cmd.commit) begin
      first_r     <= 1'b0;
      prev_time_r <= now_r;
      prev_rx_r   <= acc_rx_r;
      share_r     <= share_new;
      if (share_new != share_r) last_change_r <= now_r;
      acc_rx_r    <= '0;
      acc_tx_r    <= '0;
      acc_rxp_r   <= '0;
      acc_dly_r   <= '0;
      heavy_r     <= '0;
    end else if (cmd.acc_en && hit) begin
      acc_rx_r  <= acc_rx_r + {16'b0, in_rx_bytes};
      acc_tx_r  <= acc_tx_r + {32'b0, in_tx_packets};
      acc_rxp_r <= acc_rxp_r + {32'b0, in_rx_packets};
      acc_dly_r <= acc_dly_r + {16'b0, in_delay_sum_us};
      if (heavy_r != 16'hFFFF) heavy_r <= heavy_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) now_r <= in_now_ms;
    diff_r <= acc_tx_r - acc_rxp_r;
    prod_r <= diff_r * 78'd15625;
  end

  assign dt         = now_r - prev_time_r;
  assign db         = acc_rx_r - prev_rx_r;
  assign score_sum  = 20'(lsc_r * 20'd500) + 20'(dsc_r * 20'd300) + 20'(ssc_r * 20'd200);
  // divide by 1000: multiply by ceil(2^30 / 1000), exact for sums up to 10^6
  assign score_prod = {21'b0, sum_r} * 41'd1073742;

  always_comb begin
    dvd_nxt = '0;
    dvs_nxt = 64'd1;
    case (cmd.op)
      OP_LOAD: begin
        if (!first_r && (now_r > prev_time_r)) begin
          dvd_nxt = {17'b0, db, 3'b0};
          dvs_nxt = {32'b0, dt};
        end
      end
      OP_DELAY: begin
        if (acc_rxp_r != '0) begin
          dvd_nxt = {20'b0, acc_dly_r};
          dvs_nxt = acc_rxp_r;
        end
      end
      OP_LOSS: begin
        if ((acc_tx_r != '0) && (acc_rxp_r < acc_tx_r)) begin
          if (acc_rxp_r == '0) begin
            dvd_nxt = {64'b0, LOSS_FULL};
          end else begin
            dvd_nxt = {prod_r, 6'b0};
            dvs_nxt = acc_tx_r;
          end
        end
      end
      OP_LSC: begin
        dvd_nxt = {42'b0, 42'(load_r * 42'd1000)};
        dvs_nxt = (ref_load_r == '0) ? 64'd1 : {40'b0, ref_load_r};
      end
      OP_DSC: begin
        dvd_nxt = {42'b0, 42'(delay_r * 42'd1000)};
        dvs_nxt = (ref_delay_r == '0) ? 64'd1 : {40'b0, ref_delay_r};
      end
      OP_SSC: begin
        dvd_nxt = {54'b0, 30'(loss_r * 30'd1000)};
        dvs_nxt = (ref_loss_r == '0) ? 64'd1 : {44'b0, ref_loss_r};
      end
      default: ;
    endcase
  end

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dvd_r <= dvd_nxt;
      dvs_r <= dvs_nxt;
      rem_r <= '0;
      quo_r <= '0;
      sat_r <= 1'b0;
      cnt_r <= '0;
      sum_r <= score_sum;
    end else if (cmd.run) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      sat_r <= sat_r | quo_r[QUO_W-1];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.div_done = (cnt_r == CNT_W'(DIV_ITER - 1));
  assign quo_sat      = sat_r ? 32'hFFFF_FFFF : quo_r;
  assign quo_clamp    = (sat_r || (quo_r > {22'b0, SCORE_MAX})) ? SCORE_MAX : quo_r[9:0];

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_LOAD:  load_r  <= quo_sat;
        OP_DELAY: delay_r <= quo_sat;
        OP_LOSS:  loss_r  <= quo_r[19:0];
        OP_LSC:   lsc_r   <= quo_clamp;
        OP_DSC:   dsc_r   <= quo_clamp;
        OP_SSC:   ssc_r   <= quo_clamp;
        OP_SCORE: score_r <= score_prod[39:30];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ratio_6ghz_tenths <= share_new;
      out_ratio_5ghz_tenths <= SHARE_TOTAL - share_new;
      out_score_permille    <= score_r;
      out_load_kbps         <= load_r;
      out_mean_delay_us     <= delay_r;
      out_loss_ppm          <= loss_r;
      out_heavy_flows       <= heavy_r;
      out_ratio_changed     <= (share_new != share_r);
    end
  end

endmodule
